/* hw/rtl/serial_provisioning_line_parser_unit_assert.svh */
// Assertion macros for the provisioning line parser.
`ifndef SERIAL_PROVISIONING_LINE_PARSER_UNIT_ASSERT_SVH
`define SERIAL_PROVISIONING_LINE_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SPL_ASSERT_IMPL(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("%m: check failed");
`define SPL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("%m: check failed");
`else
`define SPL_ASSERT_IMPL(label, clk, rst, cond)
`define SPL_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hw/rtl/spl_pkg.sv */
`default_nettype none
package spl_pkg;
   localparam int LINE_BYTES_DEF  = 256;
   localparam int TOKEN_CHARS_DEF = 64;
   localparam int NAME_MAX_DEF    = 32;
   localparam int PASS_MAX_DEF    = 64;

   localparam int TOKEN_PFX_LEN = 14;
   localparam int WIFI_PFX_LEN  = 18;

   // Message codes of a result beat.
   localparam logic [3:0] MSG_READY     = 4'd0;
   localparam logic [3:0] MSG_TOKEN_OK  = 4'd1;
   localparam logic [3:0] MSG_TOKEN_LEN = 4'd2;
   localparam logic [3:0] MSG_TOKEN_HEX = 4'd3;
   localparam logic [3:0] MSG_NAME_OK   = 4'd4;
   localparam logic [3:0] MSG_NAME_LEN  = 4'd5;
   localparam logic [3:0] MSG_PASS_OK   = 4'd6;
   localparam logic [3:0] MSG_PASS_LONG = 4'd7;
   localparam logic [3:0] MSG_UNEXPECT  = 4'd8;
   localparam logic [3:0] MSG_DONE      = 4'd9;
   localparam logic [3:0] MSG_TIMEOUT   = 4'd10;
   localparam logic [3:0] MSG_READ      = 4'd11;

   localparam logic [0:0] CSR_TIMEOUT  = 1'd0;
   localparam logic [0:0] CSR_INTERVAL = 1'd1;

   localparam logic [1:0] SEL_TOKEN = 2'd0;
   localparam logic [1:0] SEL_NAME  = 2'd1;
   localparam logic [1:0] SEL_PASS  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_POLL,
      ST_SCAN,
      ST_CHECK,
      ST_COPY,
      ST_CLEAR,
      ST_EMIT
   } state_type;

   // Which prefix a scanned line still matches.
   typedef struct packed {
      logic tok;
      logic nam;
      logic pas;
   } match_type;

   function automatic logic [7:0] pfx_char(input logic [1:0] which, input logic [4:0] i);
      logic [7:0] c;
      c = 8'd0;
      unique case (i)
         5'd0: c = 8'd86;  5'd1: c = 8'd73;  5'd2: c = 8'd69;  5'd3: c = 8'd87;
         5'd4: c = 8'd79;  5'd5: c = 8'd87;  5'd6: c = 8'd76;  5'd7: c = 8'd95;
         default: begin
            if (which == SEL_TOKEN) begin
               unique case (i)
                  5'd8: c = 8'd84;  5'd9: c = 8'd79;  5'd10: c = 8'd75;
                  5'd11: c = 8'd69; 5'd12: c = 8'd78; 5'd13: c = 8'd58;
                  default: c = 8'd0;
               endcase
            end else begin
               unique case (i)
                  5'd8: c = 8'd87;  5'd9: c = 8'd73;  5'd10: c = 8'd70;
                  5'd11: c = 8'd73; 5'd12: c = 8'd95;
                  5'd13: c = (which == SEL_NAME) ? 8'd83 : 8'd80;
                  5'd14: c = (which == SEL_NAME) ? 8'd83 : 8'd65;
                  5'd15: c = (which == SEL_NAME) ? 8'd73 : 8'd83;
                  5'd16: c = (which == SEL_NAME) ? 8'd68 : 8'd83;
                  5'd17: c = 8'd58;
                  default: c = 8'd0;
               endcase
            end
         end
      endcase
      return c;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102) ||
             (c >= 8'd65 && c <= 8'd70);
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/spl_line_ram.sv */
`default_nettype none
module spl_line_ram #(
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [7:0]               wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);
   logic [7:0] mem [DEPTH];

   // Line bytes in a simple dual-port style buffer with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/spl_value_ram.sv */
`default_nettype none
module spl_value_ram (
   input  wire        clock,
   input  wire        wr_en,
   input  wire  [7:0] wr_addr,
   input  wire  [7:0] wr_data,
   input  wire  [7:0] rd_addr,
   output logic [7:0] rd_data
);
   // Stored values: token at 0, name at 64, password at 128.
   logic [7:0] mem [192];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/serial_provisioning_line_parser_unit.sv */
`default_nettype none
// Serial provisioning line parser. Each request beat is a poll carrying an optional
// received byte, or a read of one stored value character. A read addresses the value
// memory when taken and answers from the emit step after the read step; a poll with an
// ordinary byte passes the poll step, then the emit step. A newline walks the stored
// line through the line memory one byte a cycle; an accepted value is then copied
// into its 64-byte slot of the value memory. Response stalls hold the emit step. After
// reset a clearing pass zeroes all 192 bytes of the value memory before the first
// request beat is taken. Up to three response beats follow one poll, the final one
// marked by rsp_last.
module serial_provisioning_line_parser_unit
   import spl_pkg::*;
#(
   parameter int LINE_BYTES  = spl_pkg::LINE_BYTES_DEF,
   parameter int TOKEN_CHARS = spl_pkg::TOKEN_CHARS_DEF,
   parameter int NAME_MAX    = spl_pkg::NAME_MAX_DEF,
   parameter int PASS_MAX    = spl_pkg::PASS_MAX_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [0:0]  req_operation,
   input  wire  [0:0]  req_byte_valid,
   input  wire  [7:0]  req_rx_byte,
   input  wire  [1:0]  req_read_which,
   input  wire  [5:0]  req_read_index,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [3:0]  rsp_message,
   output logic [7:0]  rsp_read_char,
   output logic [6:0]  rsp_value_length,
   output logic        rsp_last,
   input  wire         csr_write,
   input  wire  [0:0]  csr_index,
   input  wire  [23:0] csr_data
);
   `include "serial_provisioning_line_parser_unit_assert.svh"

   localparam int LW = $clog2(LINE_BYTES);
   localparam int LCW = LW + 1;

   state_type state_ff, state_in;
   logic [23:0] timeout_ff;
   logic [9:0]  interval_ff;
   logic [LCW-1:0] line_len_ff, line_len_in;
   logic [23:0] elapsed_ff, elapsed_in;
   logic [9:0]  since_ff, since_in;
   logic [6:0]  name_len_ff, name_len_in, pass_len_ff, pass_len_in;
   logic [2:0]  have_ff, have_in;
   logic        fin_ff, fin_in;
   logic [LCW-1:0] idx_ff, idx_in, eff_ff, eff_in;
   match_type   match_ff, match_in;
   logic        hexok_ff, hexok_in;
   logic        rdvalid_ff, rdvalid_in;
   logic [7:0]  clr_ff, clr_in;
   logic [1:0]  sel_ff, sel_in;
   logic [6:0]  vlen_ff, vlen_in;
   logic [6:0]  ridx_ff, ridx_in;
   // Pending response beats: three slots of message code.
   logic [3:0]  q_msg_ff [3], q_msg_in [3];
   logic [1:0]  q_cnt_ff, q_cnt_in, q_pos_ff, q_pos_in;
   logic [7:0]  q_char_ff, q_char_in;
   logic [6:0]  q_len_ff, q_len_in;
   logic [7:0]  rx_ff, rx_in;
   logic        bv_ff, bv_in;

   logic            lw_en, vw_en;
   logic [LW-1:0]   lw_addr, lr_addr;
   logic [7:0]      lw_data, lr_data, vw_addr, vw_data, vr_addr, vr_data;

   spl_line_ram #(.DEPTH(LINE_BYTES)) u_line (
      .clock(clock), .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(lw_data),
      .rd_addr(lr_addr), .rd_data(lr_data)
   );
   spl_value_ram u_value (
      .clock(clock), .wr_en(vw_en), .wr_addr(vw_addr), .wr_data(vw_data),
      .rd_addr(vr_addr), .rd_data(vr_data)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= 24'd1200;
         interval_ff <= 10'd60;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TIMEOUT:  timeout_ff  <= csr_data;
            CSR_INTERVAL: interval_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         line_len_ff <= '0; elapsed_ff <= '0; since_ff <= '0;
         name_len_ff <= '0; pass_len_ff <= '0; have_ff <= '0; fin_ff <= 1'b0;
         q_cnt_ff <= '0; q_pos_ff <= '0; clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         line_len_ff <= line_len_in; elapsed_ff <= elapsed_in; since_ff <= since_in;
         name_len_ff <= name_len_in; pass_len_ff <= pass_len_in; have_ff <= have_in;
         fin_ff <= fin_in; q_cnt_ff <= q_cnt_in; q_pos_ff <= q_pos_in; clr_ff <= clr_in;
      end
      idx_ff <= idx_in; eff_ff <= eff_in; match_ff <= match_in; hexok_ff <= hexok_in;
      rdvalid_ff <= rdvalid_in; sel_ff <= sel_in; vlen_ff <= vlen_in; ridx_ff <= ridx_in;
      q_msg_ff <= q_msg_in; q_char_ff <= q_char_in; q_len_ff <= q_len_in;
      rx_ff <= rx_in; bv_ff <= bv_in;
   end

   logic [LCW-1:0] vlen_w;
   logic [7:0]     base_w;
   logic [7:0]     cpos_w;
   logic [7:0]     pc_w;
   logic [23:0]    el_next;

   // Sequencer: clear, idle, read, poll, line scan, check, copy and emit steps.
   always_comb begin
      state_in = state_ff;
      line_len_in = line_len_ff; elapsed_in = elapsed_ff; since_in = since_ff;
      name_len_in = name_len_ff; pass_len_in = pass_len_ff; have_in = have_ff;
      fin_in = fin_ff; idx_in = idx_ff; eff_in = eff_ff; match_in = match_ff;
      hexok_in = hexok_ff; rdvalid_in = rdvalid_ff; clr_in = clr_ff; sel_in = sel_ff;
      vlen_in = vlen_ff; ridx_in = ridx_ff; q_msg_in = q_msg_ff; q_cnt_in = q_cnt_ff;
      q_pos_in = q_pos_ff; q_char_in = q_char_ff; q_len_in = q_len_ff;
      rx_in = rx_ff; bv_in = bv_ff;
      lw_en = 1'b0; lw_addr = line_len_ff[LW-1:0]; lw_data = rx_ff;
      lr_addr = idx_ff[LW-1:0];
      vw_en = 1'b0; vw_addr = clr_ff; vw_data = 8'd0; vr_addr = 8'd0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      vlen_w = '0; base_w = 8'd0; cpos_w = 8'd0; pc_w = 8'd0;
      el_next = elapsed_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            vw_en = 1'b1;
            vw_addr = clr_ff;
            clr_in = clr_ff + 8'd1;
            if (clr_ff == 8'd191) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            q_cnt_in = '0; q_pos_in = '0; q_char_in = 8'd0; q_len_in = 7'd0;
            rx_in = req_rx_byte; bv_in = req_byte_valid[0];
            sel_in = req_read_which;
            if (req_valid) begin
               if (req_operation[0]) begin
                  // Read beat: address the value memory now.
                  unique case (req_read_which)
                     SEL_TOKEN: begin
                        rdvalid_in = 32'(req_read_index) < TOKEN_CHARS;
                        vlen_in = have_ff[0] ? 7'(TOKEN_CHARS) : 7'd0;
                        vr_addr = {2'b00, req_read_index};
                     end
                     SEL_NAME: begin
                        rdvalid_in = 32'(req_read_index) < NAME_MAX;
                        vlen_in = name_len_ff;
                        vr_addr = {2'b01, req_read_index};
                     end
                     SEL_PASS: begin
                        rdvalid_in = 32'(req_read_index) < PASS_MAX;
                        vlen_in = pass_len_ff;
                        vr_addr = {2'b10, req_read_index};
                     end
                     default: begin
                        rdvalid_in = 1'b0;
                        vlen_in = 7'd0;
                     end
                  endcase
                  state_in = ST_READ;
               end else if (!fin_ff) begin
                  state_in = ST_POLL;
               end
            end
         end
         ST_READ: begin
            q_msg_in[0] = MSG_READ;
            q_char_in = rdvalid_ff ? vr_data : 8'd0;
            q_len_in = vlen_ff;
            q_cnt_in = 2'd1;
            state_in = ST_EMIT;
         end
         ST_POLL: begin
            if (elapsed_ff >= timeout_ff) begin
               q_msg_in[0] = MSG_TIMEOUT; q_cnt_in = 2'd1; fin_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               // A beacon restarts the interval count, which then advances by one.
               if (elapsed_ff == 24'd0 || since_ff >= interval_ff) begin
                  q_msg_in[0] = MSG_READY; q_cnt_in = 2'd1;
                  since_in = 10'd1;
               end else if (since_ff != 10'h3FF) begin
                  since_in = since_ff + 10'd1;
               end
               el_next = (elapsed_ff != 24'hFFFFFF) ? elapsed_ff + 24'd1 : elapsed_ff;
               elapsed_in = el_next;
               state_in = ST_EMIT;
               if (bv_ff && rx_ff != 8'd13) begin
                  if (rx_ff == 8'd10) begin
                     idx_in = '0; eff_in = '0;
                     match_in = '{tok: 1'b1, nam: 1'b1, pas: 1'b1};
                     hexok_in = 1'b1;
                     state_in = ST_SCAN;
                  end else if (32'(line_len_ff) < LINE_BYTES - 1) begin
                     lw_en = 1'b1;
                     line_len_in = line_len_ff + 1'b1;
                  end else begin
                     line_len_in = '0;
                  end
               end
               if (state_in == ST_EMIT && el_next >= timeout_ff) begin
                  q_msg_in[q_cnt_in] = MSG_TIMEOUT;
                  q_cnt_in = q_cnt_in + 2'd1;
                  fin_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // The byte of address idx is seen in the cycle after it is presented. idx_ff
            // is the next address, eff_ff counts bytes already checked.
            lr_addr = idx_ff[LW-1:0];
            if (idx_ff != eff_ff) begin
               if (lr_data == 8'd0) begin
                  state_in = ST_CHECK;
               end else begin
                  pc_w = 8'(eff_ff);
                  if (32'(eff_ff) < TOKEN_PFX_LEN) begin
                     if (lr_data != pfx_char(SEL_TOKEN, pc_w[4:0])) match_in.tok = 1'b0;
                  end else if (!is_hex(lr_data)) begin
                     hexok_in = 1'b0;
                  end
                  if (32'(eff_ff) < WIFI_PFX_LEN) begin
                     if (lr_data != pfx_char(SEL_NAME, pc_w[4:0])) match_in.nam = 1'b0;
                     if (lr_data != pfx_char(SEL_PASS, pc_w[4:0])) match_in.pas = 1'b0;
                  end
                  eff_in = eff_ff + 1'b1;
                  if (idx_ff < line_len_ff) begin
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     state_in = ST_CHECK;
                  end
               end
            end else if (idx_ff < line_len_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            line_len_in = '0;
            state_in = ST_EMIT;
            if (eff_ff != '0) begin
               if (match_ff.tok && 32'(eff_ff) >= TOKEN_PFX_LEN) begin
                  if (32'(eff_ff) != TOKEN_PFX_LEN + TOKEN_CHARS) begin
                     q_msg_in[q_cnt_ff] = MSG_TOKEN_LEN; q_cnt_in = q_cnt_ff + 2'd1;
                  end else if (!hexok_ff) begin
                     q_msg_in[q_cnt_ff] = MSG_TOKEN_HEX; q_cnt_in = q_cnt_ff + 2'd1;
                  end else begin
                     sel_in = SEL_TOKEN; vlen_in = 7'(TOKEN_CHARS);
                     state_in = ST_COPY;
                  end
               end else if (match_ff.nam && 32'(eff_ff) >= WIFI_PFX_LEN) begin
                  vlen_w = eff_ff - LCW'(WIFI_PFX_LEN);
                  if (vlen_w == '0 || 32'(vlen_w) > NAME_MAX) begin
                     q_msg_in[q_cnt_ff] = MSG_NAME_LEN; q_cnt_in = q_cnt_ff + 2'd1;
                  end else begin
                     sel_in = SEL_NAME; vlen_in = 7'(vlen_w);
                     state_in = ST_COPY;
                  end
               end else if (match_ff.pas && 32'(eff_ff) >= WIFI_PFX_LEN) begin
                  vlen_w = eff_ff - LCW'(WIFI_PFX_LEN);
                  if (32'(vlen_w) > PASS_MAX) begin
                     q_msg_in[q_cnt_ff] = MSG_PASS_LONG; q_cnt_in = q_cnt_ff + 2'd1;
                  end else begin
                     sel_in = SEL_PASS; vlen_in = 7'(vlen_w);
                     state_in = ST_COPY;
                  end
               end else begin
                  q_msg_in[q_cnt_ff] = MSG_UNEXPECT; q_cnt_in = q_cnt_ff + 2'd1;
               end
            end
            idx_in = (sel_in == SEL_TOKEN) ? LCW'(TOKEN_PFX_LEN) : LCW'(WIFI_PFX_LEN);
            ridx_in = 7'd0;
            if (state_in == ST_EMIT && elapsed_ff >= timeout_ff) begin
               q_msg_in[q_cnt_in] = MSG_TIMEOUT; q_cnt_in = q_cnt_in + 2'd1;
               fin_in = 1'b1;
            end
         end
         ST_COPY: begin
            // Read line byte at idx; write the previous one into the value slot.
            lr_addr = idx_ff[LW-1:0];
            base_w = (sel_ff == SEL_TOKEN) ? 8'd0 : ((sel_ff == SEL_NAME) ? 8'd64 : 8'd128);
            cpos_w = 8'(ridx_ff) - 8'd1;
            idx_in = idx_ff + 1'b1;
            ridx_in = ridx_ff + 7'd1;
            if (ridx_ff != 7'd0) begin
               vw_en = 1'b1;
               vw_addr = base_w + cpos_w;
               vw_data = ({1'b0, cpos_w[5:0]} < vlen_ff) ? lr_data : 8'd0;
            end
            if (ridx_ff != 7'd0 && cpos_w[5:0] == 6'd63) begin
               q_msg_in[q_cnt_ff] = (sel_ff == SEL_TOKEN) ? MSG_TOKEN_OK :
                                    ((sel_ff == SEL_NAME) ? MSG_NAME_OK : MSG_PASS_OK);
               q_cnt_in = q_cnt_ff + 2'd1;
               have_in = have_ff | ((sel_ff == SEL_TOKEN) ? 3'b001 :
                                    ((sel_ff == SEL_NAME) ? 3'b010 : 3'b100));
               if (sel_ff == SEL_NAME) name_len_in = vlen_ff;
               if (sel_ff == SEL_PASS) pass_len_in = vlen_ff;
               if (have_in == 3'b111) begin
                  q_msg_in[q_cnt_in] = MSG_DONE; q_cnt_in = q_cnt_in + 2'd1;
                  fin_in = 1'b1;
               end else if (elapsed_ff >= timeout_ff) begin
                  q_msg_in[q_cnt_in] = MSG_TIMEOUT; q_cnt_in = q_cnt_in + 2'd1;
                  fin_in = 1'b1;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (q_pos_ff == q_cnt_ff) begin
               state_in = ST_IDLE;
            end else begin
               rsp_valid = 1'b1;
               if (!rsp_stall) begin
                  q_pos_in = q_pos_ff + 2'd1;
                  if (q_pos_in == q_cnt_ff) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_message = q_msg_ff[q_pos_ff];
   assign rsp_read_char = q_char_ff;
   assign rsp_value_length = q_len_ff;
   assign rsp_last = (q_pos_ff + 2'd1) == q_cnt_ff;

   // Response beats only leave from the emit step, and never beyond the queue.
   `SPL_ASSERT_IMPL(a_rsp_in_emit, clock, reset, !rsp_valid || state_ff == ST_EMIT)
   `SPL_ASSERT_IMPL(a_queue_bound, clock, reset, q_pos_ff <= q_cnt_ff && q_cnt_ff <= 2'd3)
   `SPL_ASSERT_NEXT(a_fin_sticky, clock, reset, fin_ff, fin_ff)
endmodule
`default_nettype wire
